// ===== rtl/hpct_pkg.sv =====
// hpct_pkg: shared types and constants of the hit pair coincidence tracker
// used by the scan front, the track math back end, the queue and the top level
`timescale 1ns / 1ps

package hpct_pkg;

  localparam int MaxHitsDefault = 64;
  localparam int ResultCap      = 63;
  localparam int QueueDepth     = 4;
  localparam int QueueAw        = 2;
  localparam logic [29:0] WindowReset = 30'd100;
  localparam int DivSteps  = 24;
  localparam int SqrtSteps = 17;

  // one stored hit
  typedef struct packed {
    logic [1:0]         plane;
    logic [31:0]        ts;
    logic [29:0]        tns;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } hit_t;

  // one coincidence handed from the front to the back end
  typedef struct packed {
    logic [5:0]         idx;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [31:0]        ts;
    logic [30:0]        halfns;
    logic [30:0]        diff;
    logic               last;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

// ===== rtl/hpct_queue.sv =====
// hpct_queue: short register queue of coincidence jobs between front and back
// depends on hpct_pkg
`timescale 1ns / 1ps

module hpct_queue
  import hpct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  job_t  push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output job_t  pop_data
);

  job_t               slots [QueueDepth];
  logic [QueueAw-1:0] wptr;
  logic [QueueAw-1:0] rptr;
  logic [QueueAw:0]   fill;

  assign full     = (fill == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  assign empty    = (fill == '0);
  assign pop_data = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) wptr <= wptr + 1'b1;
      if (pop && !empty) rptr <= rptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/hpct_front.sv =====
// hpct_front: hit store, window register and pairwise scan of stored hits
// depends on hpct_pkg; pushes coincidence jobs into hpct_queue
`timescale 1ns / 1ps

module hpct_front
  import hpct_pkg::*;
#(
  parameter int MAX_HITS = MaxHitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first_of_event,
  input  hit_t        hit_in,
  output qctl_t       qctl,
  input  logic        q_full,
  output job_t        job
);

  localparam int Aw = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam logic [Aw:0] MaxCount = (Aw+1)'(MAX_HITS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_FIN  = 3'b100
  } fstate_t;

  fstate_t     state;
  hit_t        store [MAX_HITS];
  hit_t        rdata;
  hit_t        h;
  logic [29:0] window;
  logic [Aw:0] stored_count;
  logic [Aw:0] scan_n;
  logic [Aw:0] ridx;
  logic [Aw-1:0] cidx;
  logic        cv;
  logic [5:0]  mcount;
  job_t        pend;
  logic        pend_v;
  logic        issue;
  logic        match_ok;
  logic        stall;
  logic        fin_go;
  logic [29:0] adt;
  job_t        cur;

  assign in_ready = (state == F_IDLE);

  // compare the registered store entry with the held hit
  always_comb begin
    adt = (rdata.tns >= h.tns) ? rdata.tns - h.tns : h.tns - rdata.tns;
    match_ok = cv && (rdata.plane != h.plane) && (rdata.ts == h.ts)
               && (adt < window) && (mcount < 6'(ResultCap));
    stall = match_ok && pend_v && q_full;
    issue = (state == F_SCAN) && (ridx < scan_n) && (mcount < 6'(ResultCap)) && !stall;
    fin_go = (state == F_FIN) && (!pend_v || !q_full);
    cur.idx    = 6'(cidx);
    cur.px     = rdata.x;
    cur.py     = rdata.y;
    cur.pz     = rdata.z;
    cur.nx     = h.x;
    cur.ny     = h.y;
    cur.nz     = h.z;
    cur.ts     = h.ts;
    cur.halfns = 31'(rdata.tns) + 31'(h.tns);
    cur.diff   = 31'(rdata.tns) - 31'(h.tns);
    cur.last   = 1'b0;
  end

  // queue push: previous match on a new match, final match at the end
  always_comb begin
    qctl.full = q_full;
    qctl.push = 1'b0;
    job       = pend;
    if (state == F_SCAN && match_ok && pend_v && !q_full) begin
      qctl.push = 1'b1;
    end else if (fin_go && pend_v) begin
      qctl.push = 1'b1;
      job.last  = 1'b1;
    end
  end

  // store read and write
  always_ff @(posedge clk) begin
    if (issue) rdata <= store[ridx[Aw-1:0]];
    if (fin_go && scan_n < MaxCount) store[scan_n[Aw-1:0]] <= h;
  end

  // held hit and pending job
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) h <= hit_in;
    if (state == F_SCAN && match_ok && !stall) pend <= cur;
    if (issue) cidx <= ridx[Aw-1:0];
  end

  // window register
  always_ff @(posedge clk) begin
    if (rst) window <= WindowReset;
    else if (cfg_we) window <= cfg_wdata;
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      stored_count <= '0;
      scan_n       <= '0;
      ridx         <= '0;
      cv           <= 1'b0;
      mcount       <= '0;
      pend_v       <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            scan_n <= first_of_event ? '0 : stored_count;
            ridx   <= '0;
            cv     <= 1'b0;
            mcount <= '0;
            pend_v <= 1'b0;
            state  <= F_SCAN;
          end
        end
        F_SCAN: begin
          if (!stall) begin
            cv <= issue;
            if (issue) ridx <= ridx + 1'b1;
            if (match_ok) begin
              mcount <= mcount + 1'b1;
              pend_v <= 1'b1;
            end
            if (!issue && !cv) state <= F_FIN;
          end
        end
        F_FIN: begin
          if (fin_go) begin
            pend_v       <= 1'b0;
            stored_count <= (scan_n < MaxCount) ? scan_n + 1'b1 : scan_n;
            state        <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // store count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= MaxCount) else $error("stored hit count beyond depth");

  // never more matches per hit than the result cap
  a_cap: assert property (@(posedge clk) disable iff (rst)
    mcount <= 6'(ResultCap)) else $error("match count beyond cap");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(qctl.push && q_full)) else $error("push into full queue");

endmodule

// ===== rtl/hpct_back.sv =====
// hpct_back: track math per coincidence (length by digit square root, two ratios
// by restoring division) and the output register; depends on hpct_pkg
`timescale 1ns / 1ps

module hpct_back
  import hpct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  job_t        q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  partner_index,
  output logic signed [15:0] partner_x,
  output logic signed [15:0] partner_y,
  output logic signed [15:0] partner_z,
  output logic [31:0] track_s,
  output logic [30:0] track_halfns,
  output logic signed [30:0] time_diff_ns,
  output logic [16:0] path_length,
  output logic [15:0] ratio_yx,
  output logic [15:0] ratio_yz,
  output logic        last_of_run
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_DIFF = 5'b00010,
    B_SQR  = 5'b00100,
    B_ITER = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t     state;
  job_t        j;
  logic [15:0] dx, dy, dz;
  logic [31:0] sx, sy, sz;
  logic [33:0] rad;
  logic [19:0] srem;
  logic [16:0] root;
  logic [23:0] nyx, nyz;
  logic [23:0] qyx, qyz;
  logic [15:0] ryx, ryz;
  logic [4:0]  step;
  logic [16:0] ax, ay, az;
  logic [21:0] srem4;
  logic [18:0] trial;
  logic [16:0] dyx2, dyz2;
  logic        load_out;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign load_out = (state == B_OUT) && (!out_valid || out_ready);

  // absolute position differences
  always_comb begin
    ax = {j.px[15], j.px} - {j.nx[15], j.nx};
    ay = {j.py[15], j.py} - {j.ny[15], j.ny};
    az = {j.pz[15], j.pz} - {j.nz[15], j.nz};
    ax = ax[16] ? 17'(-ax) : ax;
    ay = ay[16] ? 17'(-ay) : ay;
    az = az[16] ? 17'(-az) : az;
  end

  // one square root digit and one quotient bit of each ratio per step
  always_comb begin
    srem4 = {srem, rad[33:32]};
    trial = {root, 2'b01};
    dyx2  = {ryx, nyx[23]};
    dyz2  = {ryz, nyz[23]};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) j <= q_data;
      end
      B_DIFF: begin
        dx <= ax[15:0];
        dy <= ay[15:0];
        dz <= az[15:0];
      end
      B_SQR: begin
        sx   <= dx * dx;
        sy   <= dy * dy;
        sz   <= dz * dz;
        nyx  <= {dy, 8'd0};
        nyz  <= {dy, 8'd0};
        ryx  <= '0;
        ryz  <= '0;
        srem <= '0;
        root <= '0;
      end
      B_ITER: begin
        if (step == 5'd0) begin
          rad <= 34'(sx) + 34'(sy) + 34'(sz);
        end else begin
          if (step <= 5'(SqrtSteps)) begin
            rad <= {rad[31:0], 2'b00};
            if (22'(trial) <= srem4) begin
              srem <= 20'(srem4 - 22'(trial));
              root <= {root[15:0], 1'b1};
            end else begin
              srem <= srem4[19:0];
              root <= {root[15:0], 1'b0};
            end
          end
          nyx <= {nyx[22:0], 1'b0};
          nyz <= {nyz[22:0], 1'b0};
          if (dyx2 >= {1'b0, dx}) begin
            ryx <= 16'(dyx2 - {1'b0, dx});
            qyx <= {qyx[22:0], 1'b1};
          end else begin
            ryx <= dyx2[15:0];
            qyx <= {qyx[22:0], 1'b0};
          end
          if (dyz2 >= {1'b0, dz}) begin
            ryz <= 16'(dyz2 - {1'b0, dz});
            qyz <= {qyz[22:0], 1'b1};
          end else begin
            ryz <= dyz2[15:0];
            qyz <= {qyz[22:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      partner_index <= j.idx;
      partner_x     <= j.px;
      partner_y     <= j.py;
      partner_z     <= j.pz;
      track_s       <= j.ts;
      track_halfns  <= j.halfns;
      time_diff_ns  <= j.diff;
      path_length   <= root;
      ratio_yx      <= (dx == '0 || qyx[23:16] != '0) ? 16'hFFFF : qyx[15:0];
      ratio_yz      <= (dz == '0 || qyz[23:16] != '0) ? 16'hFFFF : qyz[15:0];
      last_of_run   <= j.last;
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && !out_ready);
      case (state)
        B_IDLE: if (!q_empty) state <= B_DIFF;
        B_DIFF: state <= B_SQR;
        B_SQR: begin
          step  <= '0;
          state <= B_ITER;
        end
        B_ITER: begin
          step <= step + 1'b1;
          if (step == 5'(DivSteps)) state <= B_OUT;
        end
        B_OUT: begin
          if (load_out) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // a loaded beat is offered on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid) else $error("loaded beat not offered");

  // a waiting beat is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_length))
    else $error("waiting beat lost");

  // jobs are taken only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("pop from empty queue");

endmodule

// ===== rtl/hit_pair_coincidence_tracker.sv =====
// hit_pair_coincidence_tracker: top level joining scan front, job queue and math back
// depends on hpct_pkg, hpct_front, hpct_queue, hpct_back
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  in      | in_valid / in_ready  | first_of_event, plane, time_s, time_ns, pos_x/y/z
//  out     | out_valid/ out_ready | partner_*, track_*, time_diff_ns, path_length, ratio_*, last_of_run
//  cfg     | cfg_we               | cfg_wdata (coincidence window, ns)
//
// a hit is scanned against the stored hits, one store read per cycle unless a full job queue stalls the scan
// the back end works one job at a time through diff, square and iterate (24 quotient bits), then output
// the scan stalls when a job must be pushed into the four-deep job queue while it is full
// reset clears the store count, the queue and both sequencers; window resets to 100

module hit_pair_coincidence_tracker
  import hpct_pkg::*;
#(
  parameter int MAX_HITS = MaxHitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        first_of_event,
  input  logic [1:0]  plane,
  input  logic [31:0] time_s,
  input  logic [29:0] time_ns,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  partner_index,
  output logic signed [15:0] partner_x,
  output logic signed [15:0] partner_y,
  output logic signed [15:0] partner_z,
  output logic [31:0] track_s,
  output logic [30:0] track_halfns,
  output logic signed [30:0] time_diff_ns,
  output logic [16:0] path_length,
  output logic [15:0] ratio_yx,
  output logic [15:0] ratio_yz,
  output logic        last_of_run
);

  hit_t  hit_in;
  qctl_t qctl;
  job_t  push_job;
  job_t  pop_job;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  // incoming beat as one hit
  assign hit_in = '{plane: plane, ts: time_s, tns: time_ns, x: pos_x, y: pos_y, z: pos_z};

  hpct_front #(.MAX_HITS(MAX_HITS)) u_front (
    .clk, .rst, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .first_of_event,
    .hit_in, .qctl, .q_full, .job(push_job)
  );

  hpct_queue u_queue (
    .clk, .rst, .push(qctl.push), .push_data(push_job), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(pop_job)
  );

  hpct_back u_back (
    .clk, .rst, .q_empty, .q_data(pop_job), .q_pop, .out_valid, .out_ready,
    .partner_index, .partner_x, .partner_y, .partner_z, .track_s, .track_halfns,
    .time_diff_ns, .path_length, .ratio_yx, .ratio_yz, .last_of_run
  );

endmodule
